/* src/rfalu_pkg.sv */
// ----------------------------------------------------------------------------
// rfalu_pkg
// Shared types, constants and a helper function for the register file and ALU
// command processor.
// ----------------------------------------------------------------------------
package rfalu_pkg;

   localparam int REG_COUNT  = 16;
   localparam int ADDR_W     = $clog2(REG_COUNT);
   localparam int OPND_W     = 8;
   localparam int RESULT_W   = 16;
   localparam int DIV_STEPS  = OPND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Command byte codes.
   localparam logic [7:0] CMD_WRITE   = 8'd170;
   localparam logic [7:0] CMD_READ    = 8'd187;
   localparam logic [7:0] CMD_ALU_OPS = 8'd204;
   localparam logic [7:0] CMD_ALU     = 8'd221;

   // ALU function codes.
   localparam logic [7:0] FN_ADD  = 8'd0;
   localparam logic [7:0] FN_SUB  = 8'd1;
   localparam logic [7:0] FN_MUL  = 8'd2;
   localparam logic [7:0] FN_DIV  = 8'd3;
   localparam logic [7:0] FN_AND  = 8'd4;
   localparam logic [7:0] FN_OR   = 8'd5;
   localparam logic [7:0] FN_NAND = 8'd6;
   localparam logic [7:0] FN_NOR  = 8'd7;
   localparam logic [7:0] FN_XOR  = 8'd8;
   localparam logic [7:0] FN_XNOR = 8'd9;
   localparam logic [7:0] FN_EQ   = 8'd10;
   localparam logic [7:0] FN_GT   = 8'd11;
   localparam logic [7:0] FN_LT   = 8'd12;
   localparam logic [7:0] FN_SHR  = 8'd13;
   localparam logic [7:0] FN_SHL  = 8'd14;

   // Compare results.
   localparam logic [RESULT_W-1:0] CMP_EQ_VAL = RESULT_W'(1);
   localparam logic [RESULT_W-1:0] CMP_GT_VAL = RESULT_W'(2);
   localparam logic [RESULT_W-1:0] CMP_LT_VAL = RESULT_W'(3);

   // Register file contents after reset.
   localparam logic [OPND_W-1:0] RST_REG0 = 8'd0;
   localparam logic [OPND_W-1:0] RST_REG1 = 8'd1;
   localparam logic [OPND_W-1:0] RST_REG2 = 8'd129;
   localparam logic [OPND_W-1:0] RST_REG3 = 8'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_WB
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic div_start;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_sts_type;

   function automatic logic [OPND_W-1:0] rf_reset_value(input logic [ADDR_W-1:0] idx);
      logic [OPND_W-1:0] val;
      case (idx)
         ADDR_W'(0): val = RST_REG0;
         ADDR_W'(1): val = RST_REG1;
         ADDR_W'(2): val = RST_REG2;
         ADDR_W'(3): val = RST_REG3;
         default:    val = OPND_W'(idx);
      endcase
      return val;
   endfunction

endpackage

/* src/rfalu_ctrl.sv */
// ----------------------------------------------------------------------------
// rfalu_ctrl
// Controller state machine: sequences capture, optional divide, and result
// write-back, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rfalu_ctrl
   import rfalu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd,
   input  dp_sts_type dp_sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dp_cmd       = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_sts.need_div) begin
               dp_cmd.div_start = 1'b1;
               state_in         = ST_DIV;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (dp_sts.div_last) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (out_free) begin
               dp_cmd.commit = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("Accepted transaction did not move to execute.");

   a_rsp_not_dropped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("Pending response was dropped.");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !dp_sts.div_last) |=> (state_ff == ST_DIV))
      else $error("Divider left before its last step.");

endmodule

/* src/rfalu_dp.sv */
// ----------------------------------------------------------------------------
// rfalu_dp
// Datapath: captured command, register file, ALU with a shift-subtract
// divider, and the response payload register.
// ----------------------------------------------------------------------------
module rfalu_dp
   import rfalu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_frame_done,
   input  logic [7:0]          req_cmd_byte,
   input  logic [7:0]          req_first_byte,
   input  logic [7:0]          req_second_byte,
   input  logic [7:0]          req_third_byte,
   output logic [RESULT_W-1:0] rsp_result,
   output logic                rsp_cmd_ok,
   input  dp_cmd_type          dp_cmd,
   output dp_sts_type          dp_sts
);

   logic                done_ff;
   logic [7:0]          cmd_ff, b1_ff, b2_ff, b3_ff;
   logic [OPND_W-1:0]   rf_ff [REG_COUNT];
   logic [OPND_W-1:0]   quo_ff, rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [RESULT_W-1:0] result_ff, result_in;
   logic                ok_ff, ok_in;

   logic                is_write, is_read, is_alu_ops, is_alu, is_alu_any;
   logic [ADDR_W-1:0]   addr;
   logic [OPND_W-1:0]   opa, opb;
   logic [7:0]          fn;
   logic [RESULT_W-1:0] ea, eb, alu_res;
   logic [OPND_W:0]     rem_sh;
   logic [OPND_W+1:0]   trial;
   logic                ge;

   assign is_write   = done_ff && (cmd_ff == CMD_WRITE);
   assign is_read    = done_ff && (cmd_ff == CMD_READ);
   assign is_alu_ops = done_ff && (cmd_ff == CMD_ALU_OPS);
   assign is_alu     = done_ff && (cmd_ff == CMD_ALU);
   assign is_alu_any = is_alu_ops || is_alu;

   assign addr = b1_ff[ADDR_W-1:0];
   assign opa  = is_alu_ops ? b1_ff : rf_ff[0];
   assign opb  = is_alu_ops ? b2_ff : rf_ff[1];
   assign fn   = is_alu_ops ? b3_ff : b1_ff;
   assign ea   = RESULT_W'(opa);
   assign eb   = RESULT_W'(opb);

   assign dp_sts.need_div = is_alu_any && (fn == FN_DIV) && (opb != '0);
   assign dp_sts.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // One quotient bit per step, restoring form.
   assign rem_sh = {rem_ff, quo_ff[OPND_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, opb};
   assign ge     = !trial[OPND_W+1];

   always_comb begin
      case (fn)
         FN_ADD:  alu_res = ea + eb;
         FN_SUB:  alu_res = ea - eb;
         FN_MUL:  alu_res = ea * eb;
         FN_DIV:  alu_res = (opb == '0) ? '0 : RESULT_W'(quo_ff);
         FN_AND:  alu_res = ea & eb;
         FN_OR:   alu_res = ea | eb;
         FN_NAND: alu_res = ~(ea & eb);
         FN_NOR:  alu_res = ~(ea | eb);
         FN_XOR:  alu_res = ea ^ eb;
         FN_XNOR: alu_res = ~(ea ^ eb);
         FN_EQ:   alu_res = (opa == opb) ? CMP_EQ_VAL : '0;
         FN_GT:   alu_res = (opa > opb) ? CMP_GT_VAL : '0;
         FN_LT:   alu_res = (opa < opb) ? CMP_LT_VAL : '0;
         FN_SHR:  alu_res = ea >> 1;
         FN_SHL:  alu_res = ea << 1;
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      result_in = '0;
      ok_in     = 1'b0;
      if (is_write) begin
         result_in = RESULT_W'(b2_ff);
         ok_in     = 1'b1;
      end else if (is_read) begin
         result_in = RESULT_W'(rf_ff[addr]);
         ok_in     = 1'b1;
      end else if (is_alu_any) begin
         result_in = alu_res;
         ok_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         done_ff <= req_frame_done;
         cmd_ff  <= req_cmd_byte;
         b1_ff   <= req_first_byte;
         b2_ff   <= req_second_byte;
         b3_ff   <= req_third_byte;
      end
      if (dp_cmd.div_start) begin
         quo_ff <= opa;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (dp_cmd.div_step) begin
         quo_ff <= {quo_ff[OPND_W-2:0], ge};
         rem_ff <= ge ? trial[OPND_W-1:0] : rem_sh[OPND_W-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (dp_cmd.commit) begin
         result_ff <= result_in;
         ok_ff     <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= rf_reset_value(ADDR_W'(i));
         end
      end else if (dp_cmd.commit) begin
         if (is_write) begin
            rf_ff[addr] <= b2_ff;
         end else if (is_alu_ops) begin
            rf_ff[0] <= b1_ff;
            rf_ff[1] <= b2_ff;
         end
      end
   end

   assign rsp_result = result_ff;
   assign rsp_cmd_ok = ok_ff;

   a_div_identity: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.div_step && dp_sts.div_last) |=>
         ((16'(quo_ff) * 16'(opb) + 16'(rem_ff)) == 16'(opa)))
      else $error("Divider quotient and remainder do not rebuild the dividend.");

endmodule

/* src/regfile_alu_command_processor.sv */
// ----------------------------------------------------------------------------
// regfile_alu_command_processor
// Executes one completed command frame per transaction against a 16-entry
// byte register file and a 15-function ALU.
// ----------------------------------------------------------------------------
// A request transaction carries one decoded command frame; every request
// yields exactly one response transaction. Command 170 writes a register and
// returns the byte, 187 reads a register, 204 loads operands into registers 0
// and 1 and runs the ALU on them, and 221 runs the ALU on registers 0 and 1.
// A frame that is not complete, or an unknown command, returns 0 with cmd_ok
// low and changes nothing. A transaction passes through capture, decode and
// write-back from acceptance to a registered response; a divide with a
// nonzero divisor adds a divide phase, as the quotient comes from a shift and
// subtract divider that produces one bit per cycle. The next request is taken
// as soon as the write-back is done, even while the previous response still
// waits in the output register; write-back itself waits for that register to
// drain. The register file comes out of reset holding 0, 1, 129 and 32 in
// entries 0 to 3 and its own index in every other entry.
// ----------------------------------------------------------------------------
module regfile_alu_command_processor
   import rfalu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_frame_done,
   input  logic [7:0]          req_cmd_byte,
   input  logic [7:0]          req_first_byte,
   input  logic [7:0]          req_second_byte,
   input  logic [7:0]          req_third_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RESULT_W-1:0] rsp_result,
   output logic                rsp_cmd_ok
);

   // Command and status bundles between the controller and the datapath.
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // The controller owns both handshakes and sequences each transaction.
   rfalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   // The datapath holds the register file, the ALU, the divider and the
   // response payload register.
   rfalu_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_frame_done  (req_frame_done),
      .req_cmd_byte    (req_cmd_byte),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .rsp_result      (rsp_result),
      .rsp_cmd_ok      (rsp_cmd_ok),
      .dp_cmd          (dp_cmd),
      .dp_sts          (dp_sts)
   );

endmodule

/* dv/regfile_alu_command_processor_checker.sv */
// ----------------------------------------------------------------------------
// regfile_alu_command_processor_checker
// Watches both channels of the command processor, keeps its own copy of the
// register file, predicts the response of every accepted request and compares
// every accepted response against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module regfile_alu_command_processor_checker
   import rfalu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_frame_done,
   input  logic [7:0]          req_cmd_byte,
   input  logic [7:0]          req_first_byte,
   input  logic [7:0]          req_second_byte,
   input  logic [7:0]          req_third_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [RESULT_W-1:0] rsp_result,
   input  logic                rsp_cmd_ok,
   output int                  mismatch_count,
   output int                  outstanding_count
);

   typedef struct {
      logic [RESULT_W-1:0] result;
      logic                cmd_ok;
   } response_type;

   logic [OPND_W-1:0] reg_shadow [REG_COUNT];
   response_type      expected_responses [$];

   initial begin
      mismatch_count    = 0;
      outstanding_count = 0;
   end

   function automatic logic [RESULT_W-1:0] alu_compute(input logic [7:0] fn,
                                                       input logic [OPND_W-1:0] a,
                                                       input logic [OPND_W-1:0] b);
      logic [31:0] wa;
      logic [31:0] wb;
      logic [31:0] r;
      wa = 32'(a);
      wb = 32'(b);
      case (fn)
         FN_ADD:  r = wa + wb;
         FN_SUB:  r = wa - wb;
         FN_MUL:  r = wa * wb;
         FN_DIV:  r = (wb != 32'd0) ? wa / wb : 32'd0;
         FN_AND:  r = wa & wb;
         FN_OR:   r = wa | wb;
         FN_NAND: r = ~(wa & wb);
         FN_NOR:  r = ~(wa | wb);
         FN_XOR:  r = wa ^ wb;
         FN_XNOR: r = ~(wa ^ wb);
         FN_EQ:   r = (wa == wb) ? 32'(CMP_EQ_VAL) : 32'd0;
         FN_GT:   r = (wa > wb)  ? 32'(CMP_GT_VAL) : 32'd0;
         FN_LT:   r = (wa < wb)  ? 32'(CMP_LT_VAL) : 32'd0;
         FN_SHR:  r = wa >> 1;
         FN_SHL:  r = wa << 1;
         default: r = 32'd0;
      endcase
      return r[RESULT_W-1:0];
   endfunction

   // Applies one command to the shadow register file and returns its response.
   function automatic response_type predict_command(input logic       done,
                                                    input logic [7:0] cmd,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3);
      response_type      rsp;
      logic [ADDR_W-1:0] addr;
      addr       = b1[ADDR_W-1:0];
      rsp.result = '0;
      rsp.cmd_ok = 1'b0;
      if (done) begin
         case (cmd)
            CMD_WRITE: begin
               reg_shadow[addr] = b2;
               rsp.result       = RESULT_W'(b2);
               rsp.cmd_ok       = 1'b1;
            end
            CMD_READ: begin
               rsp.result = RESULT_W'(reg_shadow[addr]);
               rsp.cmd_ok = 1'b1;
            end
            CMD_ALU_OPS: begin
               reg_shadow[0] = b1;
               reg_shadow[1] = b2;
               rsp.result    = alu_compute(b3, b1, b2);
               rsp.cmd_ok    = 1'b1;
            end
            CMD_ALU: begin
               rsp.result = alu_compute(b1, reg_shadow[0], reg_shadow[1]);
               rsp.cmd_ok = 1'b1;
            end
            default: ;
         endcase
      end
      return rsp;
   endfunction

   always @(posedge clock) begin
      response_type oldest;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) reg_shadow[i] = OPND_W'(i);
         reg_shadow[0] = RST_REG0;
         reg_shadow[1] = RST_REG1;
         reg_shadow[2] = RST_REG2;
         reg_shadow[3] = RST_REG3;
         expected_responses.delete();
      end else begin
         // The response side goes first: a response accepted at this edge can
         // never belong to a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response result=%h cmd_ok=%b",
                           $realtime, rsp_result, rsp_cmd_ok);
            end else begin
               oldest = expected_responses.pop_front();
               if (rsp_result !== oldest.result || rsp_cmd_ok !== oldest.cmd_ok) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch result exp=%h act=%h cmd_ok exp=%b act=%b",
                              $realtime, oldest.result, rsp_result,
                              oldest.cmd_ok, rsp_cmd_ok);
               end
            end
         end
         if (req_valid && req_ready)
            expected_responses.push_back(predict_command(req_frame_done, req_cmd_byte,
                                                         req_first_byte, req_second_byte,
                                                         req_third_byte));
      end
      outstanding_count = expected_responses.size();
   end

endmodule

/* dv/regfile_alu_command_processor_tb.sv */
// ----------------------------------------------------------------------------
// regfile_alu_command_processor_tb
// Drives directed and random command frames into the command processor with
// bursty request traffic and a stalling response side, and reports a verdict
// from the failure count that the checker module returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module regfile_alu_command_processor_tb;
   import rfalu_pkg::*;

   // All inputs start at a known value; reset is held from time zero.
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_frame_done  = 1'b0;
   logic [7:0]          req_cmd_byte    = 8'd0;
   logic [7:0]          req_first_byte  = 8'd0;
   logic [7:0]          req_second_byte = 8'd0;
   logic [7:0]          req_third_byte  = 8'd0;
   logic                rsp_ready       = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [RESULT_W-1:0] rsp_result;
   logic                rsp_cmd_ok;

   int   mismatch_count;
   int   outstanding_count;

   // Sender pacing state: items left in the current burst.
   int   burst_left = 0;

   // Raised once by the stimulus to ask the receiver for a long hold-off.
   logic hold_off_request = 1'b0;

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   regfile_alu_command_processor i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_done  (req_frame_done),
      .req_cmd_byte    (req_cmd_byte),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result      (rsp_result),
      .rsp_cmd_ok      (rsp_cmd_ok)
   );

   regfile_alu_command_processor_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_done    (req_frame_done),
      .req_cmd_byte      (req_cmd_byte),
      .req_first_byte    (req_first_byte),
      .req_second_byte   (req_second_byte),
      .req_third_byte    (req_third_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result        (rsp_result),
      .rsp_cmd_ok        (rsp_cmd_ok),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   // Offers one request transaction. It is called at a falling edge and
   // returns at the falling edge after the transaction was accepted, with
   // valid still high, so that a following call continues the burst without
   // valid ever dropping in between.
   task automatic send_command(input logic       done,
                               input logic [7:0] cmd,
                               input logic [7:0] b1,
                               input logic [7:0] b2,
                               input logic [7:0] b3);
      req_valid       = 1'b1;
      req_frame_done  = done;
      req_cmd_byte    = cmd;
      req_first_byte  = b1;
      req_second_byte = b2;
      req_third_byte  = b3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Bursts of random length separated by random gaps. Now and then a burst
   // is long enough to give a stretch with no sender idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap       = $urandom_range(1, 12);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(40, 120);
         else
            burst_left = $urandom_range(1, 12);
      end
   endtask

   // Mostly well-formed frames with random content. The ALU function code is
   // usually a defined one, the divisor is biased toward zero, and roughly
   // one transaction in ten is noise: an unknown command byte or a frame that
   // is not complete.
   task automatic send_random_command();
      int         kind;
      logic       done;
      logic [7:0] cmd;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      kind = $urandom_range(0, 99);
      done = 1'b1;
      b1   = 8'($urandom);
      b2   = 8'($urandom);
      b3   = 8'($urandom_range(FN_ADD, FN_SHL));
      if ($urandom_range(0, 15) == 0) b3 = 8'($urandom);
      if ($urandom_range(0, 15) == 0) b2 = 8'd0;
      if (kind < 25) begin
         cmd = CMD_WRITE;
      end else if (kind < 45) begin
         cmd = CMD_READ;
      end else if (kind < 75) begin
         cmd = CMD_ALU_OPS;
      end else if (kind < 90) begin
         cmd = CMD_ALU;
         b1  = b3;
      end else if (kind < 95) begin
         cmd  = 8'($urandom);
         done = 1'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0:       cmd = CMD_WRITE;
            1:       cmd = CMD_READ;
            2:       cmd = CMD_ALU_OPS;
            default: cmd = CMD_ALU;
         endcase
         done = 1'b0;
      end
      send_command(done, cmd, b1, b2, b3);
   endtask

   // Receiver: a private stall pattern that changes style every segment, plus
   // one long hold-off on request, counted here in cycles. During the hold-off
   // the block fills up and has to stall its request side.
   always @(negedge clock) begin
      static int  segment_left   = 0;
      static int  ready_style    = 0;
      static int  hold_left      = 0;
      static bit  hold_off_taken = 1'b0;
      if (hold_off_request && !hold_off_taken) begin
         hold_off_taken = 1'b1;
         hold_left      = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(10, 150);
            ready_style  = $urandom_range(0, 3);
         end
         segment_left--;
         case (ready_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // Stimulus and verdict.
   initial begin
      int drain_cycles;
      logic [7:0] fn_a [15];
      logic [7:0] fn_b [15];

      // Operand pairs for the directed pass over every ALU function. They
      // cover the wrap of subtract below zero, the largest product, and the
      // true outcome of each of the three compares.
      fn_a = '{8'hFF, 8'h00, 8'hFF, 8'd200, 8'hF0, 8'hF0, 8'hF0, 8'hF0,
               8'hF0, 8'hF0, 8'd7, 8'd9, 8'd3, 8'hFF, 8'hFF};
      fn_b = '{8'hFF, 8'hFF, 8'hFF, 8'd7, 8'h3C, 8'h3C, 8'h3C, 8'h3C,
               8'h3C, 8'h3C, 8'd7, 8'd3, 8'd9, 8'h00, 8'h00};

      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part. First read back reset contents, including an address
      // whose upper bits must be ignored.
      send_command(1'b1, CMD_READ, 8'd2, 8'd0, 8'd0);
      send_command(1'b1, CMD_READ, 8'h13, 8'd0, 8'd0);
      // Write extremes of data and address through aliased addresses, then read back.
      send_command(1'b1, CMD_WRITE, 8'hFF, 8'hFF, 8'hFF);
      send_command(1'b1, CMD_WRITE, 8'hF5, 8'h00, 8'h00);
      send_command(1'b1, CMD_READ, 8'h0F, 8'd0, 8'd0);
      // A frame that is not complete must not write; read the entry back.
      send_command(1'b0, CMD_WRITE, 8'd3, 8'h55, 8'd0);
      send_command(1'b1, CMD_READ, 8'd3, 8'd0, 8'd0);
      // An unknown command byte.
      send_command(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      // Every ALU function with operands, then divide by zero and one code
      // outside the defined set.
      for (int fn = 0; fn < 15; fn++)
         send_command(1'b1, CMD_ALU_OPS, fn_a[fn], fn_b[fn], 8'(fn));
      send_command(1'b1, CMD_ALU_OPS, 8'd9, 8'd0, FN_DIV);
      send_command(1'b1, CMD_ALU_OPS, 8'd5, 8'd6, 8'd15);
      // The ALU on the registers just loaded, with a defined and an unknown
      // function code.
      send_command(1'b1, CMD_ALU, FN_SUB, 8'hAA, 8'h55);
      send_command(1'b1, CMD_ALU, 8'hFF, 8'd0, 8'd0);

      // Random part with the two pressure points placed inside it.
      for (int n = 0; n < 2000; n++) begin
         if (n == 500) begin
            // Long receiver hold-off while the sender keeps offering items
            // back to back, so the request side backs up.
            hold_off_request <= 1'b1;
            repeat (30) send_random_command();
         end
         if (n == 1000) begin
            // Sender pause until every outstanding response has arrived.
            req_valid = 1'b0;
            while (outstanding_count != 0) @(negedge clock);
         end
         send_random_command();
         pace_sender();
      end
      req_valid = 1'b0;

      // Drain: wait for the last responses, bounded, then keep watching to catch
      // anything the block might still emit.
      drain_cycles = 0;
      while (outstanding_count != 0 && drain_cycles < 20000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (30) @(negedge clock);

      if (mismatch_count == 0 && outstanding_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
src/rfalu_pkg.sv
src/rfalu_ctrl.sv
src/rfalu_dp.sv
src/regfile_alu_command_processor.sv
dv/regfile_alu_command_processor_checker.sv
dv/regfile_alu_command_processor_tb.sv
